FILE: src/opox_pkg.sv
// Shared types and sizing constants for the one-point order crossover block.
// No dependencies; imported by opox_seq, the top level and the checker.
`default_nettype none
package opox_pkg;

   localparam int NODES     = 64;
   localparam int GENE_W    = 6;
   localparam int CUT_W     = 7;
   localparam int GENE_SPAN = 1 << GENE_W;
   localparam int IDX_W     = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W     = $clog2(NODES + 1);
   localparam int CMP_W     = (CNT_W > CUT_W) ? CNT_W : CUT_W;
   localparam int PAIR_W    = 2 * GENE_W;

   typedef struct packed {
      logic [GENE_W-1:0] mother_gene;
      logic [GENE_W-1:0] father_gene;
      logic [CUT_W-1:0]  cut_point;
      logic              last_position;
   } req_type;

   typedef struct packed {
      logic [GENE_W-1:0] child_gene;
      logic              last_gene;
      logic              short_fill;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] load_count;
      logic [CNT_W-1:0] cut_held;
   } set_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_ctl_type;

endpackage
`default_nettype wire

FILE: src/opox_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module opox_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/opox_seq.sv
// Emission sequencer: walks the mother prefix, then scans father genes through
// one RAM read port, skipping prefix genes, and offers each child gene. Uses opox_pkg.
`default_nettype none
module opox_seq
   import opox_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire set_type               set_info,
   input  wire logic [GENE_SPAN-1:0]  present,
   input  wire logic [PAIR_W-1:0]     rd_data,
   output      logic                  rd_en,
   output      logic [IDX_W-1:0]      rd_addr,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_valid,
   output      rsp_type               rsp_data,
   output      seq_ctl_type           ctl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_CHK  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] src_ff, src_in;
   rsp_type          rsp_ff, rsp_in;

   logic              in_prefix;
   logic              last_k;
   logic [GENE_W-1:0] mother_g;
   logic [GENE_W-1:0] father_g;

   assign in_prefix = k_ff < set_info.cut_held;
   assign last_k    = k_ff == CNT_W'(NODES - 1);
   assign mother_g  = rd_data[PAIR_W-1:GENE_W];
   assign father_g  = rd_data[GENE_W-1:0];

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      rsp_in   = rsp_ff;
      rd_en    = 1'b0;
      rd_addr  = k_ff[IDX_W-1:0];
      ctl.done = 1'b0;
      ctl.busy = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               k_in     = '0;
               src_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (in_prefix) begin
               if (k_ff < set_info.load_count) begin
                  rd_en    = 1'b1;
                  state_in = ST_CHK;
               end else begin
                  rsp_in   = '{child_gene: '0, last_gene: last_k, short_fill: 1'b1};
                  state_in = ST_OUT;
               end
            end else if (src_ff < set_info.load_count) begin
               rd_en    = 1'b1;
               rd_addr  = src_ff[IDX_W-1:0];
               state_in = ST_CHK;
            end else begin
               rsp_in   = '{child_gene: '0, last_gene: last_k, short_fill: 1'b1};
               state_in = ST_OUT;
            end
         end
         ST_CHK: begin
            if (in_prefix) begin
               rsp_in   = '{child_gene: mother_g, last_gene: last_k, short_fill: 1'b0};
               state_in = ST_OUT;
            end else begin
               src_in = src_ff + 1'b1;
               if (present[father_g]) begin
                  state_in = ST_RD;
               end else begin
                  rsp_in   = '{child_gene: father_g, last_gene: last_k, short_fill: 1'b0};
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (last_k) begin
                  ctl.done = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         src_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         src_ff   <= src_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: src/one_point_order_crossover.sv
// Top level of the one-point order crossover block: load counter, cut point,
// prefix bitmap, gene RAM and emission sequencer. Uses opox_pkg, opox_ram, opox_seq.
//
// Usage:
//   req_ channel: one transaction per parent position (mother gene, father gene,
//   cut point, last mark). The cut point is taken on the first transaction of a
//   set and saturates to NODES. While loading, one transaction is taken per cycle.
//   rsp_ channel: after the transaction marked last, exactly NODES child genes
//   follow in position order; last_gene marks the final one, short_fill marks a
//   padded position.
//   Timing: after the last transaction the sequencer passes its address and
//   RAM read states before the first gene is offered. Each gene takes address,
//   RAM read and offer states (a padded position skips the RAM read), and each
//   skipped father gene repeats address and RAM read, all through one read port.
//   req_ready is low for the whole emission of a set.
//   Stall: a gene held by a low rsp_ready stays offered unchanged; the sequencer
//   waits in place.
//   Reset: clears the load count, cut point, prefix bitmap and sequencer; the
//   gene RAM is not cleared and is only read at loaded positions.
`default_nettype none
module one_point_order_crossover
   import opox_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   logic [CNT_W-1:0]     load_count_ff, load_count_in;
   logic [CNT_W-1:0]     cut_held_ff, cut_held_in;
   logic [GENE_SPAN-1:0] prefix_ff, prefix_in;

   logic                 accept;
   logic                 first;
   logic                 room;
   logic [CMP_W-1:0]     cut_ext;
   logic [CNT_W-1:0]     cut_sat;
   logic [CNT_W-1:0]     cut_eff;
   logic                 wr_en;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [PAIR_W-1:0]    rd_data;
   set_type              set_info;
   seq_ctl_type          ctl;

   assign req_ready = !ctl.busy;
   assign accept    = req_valid && req_ready;
   assign first     = load_count_ff == '0;
   assign room      = load_count_ff < CNT_W'(NODES);
   assign cut_ext   = CMP_W'(req_data.cut_point);
   assign cut_sat   = (cut_ext > CMP_W'(NODES)) ? CNT_W'(NODES) : CNT_W'(cut_ext);
   assign cut_eff   = first ? cut_sat : cut_held_ff;
   assign wr_en     = accept && room;

   always_comb begin
      load_count_in = load_count_ff;
      cut_held_in   = cut_held_ff;
      prefix_in     = prefix_ff;
      if (accept) begin
         if (first) begin
            cut_held_in = cut_sat;
            prefix_in   = '0;
         end
         if (room) begin
            load_count_in = load_count_ff + 1'b1;
            if (load_count_ff < cut_eff) begin
               prefix_in[req_data.mother_gene] = 1'b1;
            end
         end
      end
      if (ctl.done) begin
         load_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         cut_held_ff   <= '0;
         prefix_ff     <= '0;
      end else begin
         load_count_ff <= load_count_in;
         cut_held_ff   <= cut_held_in;
         prefix_ff     <= prefix_in;
      end
   end

   assign set_info = '{load_count: load_count_ff, cut_held: cut_held_ff};

   opox_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (NODES)
   ) u_gene_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_count_ff[IDX_W-1:0]),
      .wr_data ({req_data.mother_gene, req_data.father_gene}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   opox_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && req_data.last_position),
      .set_info  (set_info),
      .present   (prefix_ff),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl)
   );

endmodule
`default_nettype wire

FILE: src/opox_checker.sv
// Port-level checker for one_point_order_crossover, attached by bind.
// Uses opox_pkg.
`default_nettype none
module opox_checker
   import opox_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transaction changed or dropped");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a child gene is offered");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.short_fill |-> rsp_data.child_gene == '0)
      else $error("padded gene is not zero");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_position |=> !req_ready)
      else $error("input still taken after last position");

   a_end_of_child: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_gene |=> !rsp_valid)
      else $error("gene offered after the final gene");

endmodule

bind one_point_order_crossover opox_checker u_opox_checker (.*);
`default_nettype wire
